/* hw/rtl/cat_pkg.sv */
// ----------------------------------------------------------------------------
// cat_pkg: shared types and constants for the cyclic automaton step
// Register indexes, fixed field widths and the flag group that travels
// from the window front end to the rule back end.
// ----------------------------------------------------------------------------
package cat_pkg;

	// fixed field widths
	localparam int CELL_W      = 8;
	localparam int CFG_DATA_W  = 9;
	localparam int THRESH_W    = 4;
	localparam int COUNT_W     = 4;

	// register reset values and the smallest side
	localparam int GRID_RST    = 64;
	localparam int THRESH_RST  = 3;
	localparam int MIN_SIDE    = 3;

	// window taps: 0..2 upper row, 3..5 middle row, 6..8 newest row
	localparam int WIN_CELLS   = 9;
	localparam int WIN_CENTER  = 4;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_GRID_SIZE = 1'b0,
		CFG_THRESHOLD = 1'b1
	} cat_cfg_idx_t;

	// grid edge information for the cell at the window center
	typedef struct packed {
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic last;
	} cat_flags_t;

endpackage

/* hw/rtl/cat_if.sv */
// ----------------------------------------------------------------------------
// cat_if: channel interfaces of the cyclic automaton step
// Cell input channel, result output channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cat_in_if;
	logic                        valid;
	logic                        ready;
	logic [cat_pkg::CELL_W-1:0]  cell_value;
	logic                        drain;

	modport source (output valid, output cell_value, output drain, input ready);
	modport sink   (input valid, input cell_value, input drain, output ready);
endinterface

interface cat_out_if;
	logic                        valid;
	logic                        ready;
	logic [cat_pkg::CELL_W-1:0]  new_value;
	logic                        advanced;
	logic                        last_cell;

	modport source (output valid, output new_value, output advanced, output last_cell,
		input ready);
	modport sink   (input valid, input new_value, input advanced, input last_cell,
		output ready);
endinterface

interface cat_cfg_if;
	logic                            valid;
	logic                            ready;
	cat_pkg::cat_cfg_idx_t           index;
	logic [cat_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/cyclic_automaton_threshold_step.sv */
// ----------------------------------------------------------------------------
// cyclic_automaton_threshold_step: one generation of a threshold cyclic CA
// Accepts one item per cycle while the queue has room; the result of a cell
// leaves once grid side + 1 further items have been taken, passing through
// the window stage, queue and output register. Sustained rate is one item per
// cycle while the output is not stalled, set by the single line-buffer access
// per item. Reset clears counters, window and handshake state, sets grid side
// 64 (capped at MAX_SIZE) and threshold 3; line buffers keep whatever they hold and are not cleared.
// ----------------------------------------------------------------------------
module cyclic_automaton_threshold_step #(
	parameter int MAX_SIZE   = 256,
	parameter int VALUE_BITS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	cat_cfg_if.sink    cfg,
	cat_in_if.sink     cell_in,
	cat_out_if.source  cell_out
);
	import cat_pkg::*;

	localparam int FLAGS_W = $bits(cat_flags_t);
	localparam int CELLS_W = WIN_CELLS * VALUE_BITS;
	localparam int FIFO_W  = CELLS_W + FLAGS_W;
	localparam int Q_DEPTH = 2;

	logic                                  f_valid, f_ready, b_valid, b_ready;
	logic [WIN_CELLS-1:0][VALUE_BITS-1:0]  f_cells, b_cells;
	cat_flags_t                            f_flags, b_flags;
	logic [THRESH_W-1:0]                   threshold;
	logic [FIFO_W-1:0]                     q_in, q_out;

	cat_front #(
		.MAX_SIZE   (MAX_SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cell_in   (cell_in),
		.win_valid (f_valid),
		.win_ready (f_ready),
		.win_cells (f_cells),
		.win_flags (f_flags),
		.threshold (threshold)
	);

	// window queue
	assign q_in = {f_cells, f_flags};

	cat_fifo #(
		.WIDTH (FIFO_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_data  (q_in),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_data   (q_out)
	);

	assign b_cells = q_out[FIFO_W-1:FLAGS_W];
	assign b_flags = q_out[FLAGS_W-1:0];

	cat_back #(
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (b_valid),
		.win_ready (b_ready),
		.win_cells (b_cells),
		.win_flags (b_flags),
		.threshold (threshold),
		.cell_out  (cell_out)
	);

endmodule

/* hw/rtl/cat_fifo.sv */
// ----------------------------------------------------------------------------
// cat_fifo: short queue between the window front end and the rule back end
// Register-based FIFO with valid/ready on both sides.
// ----------------------------------------------------------------------------
module cat_fifo #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = (cnt_q != CNT_W'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

/* hw/rtl/cat_front.sv */
// ----------------------------------------------------------------------------
// cat_front: input side of the cyclic automaton step
// Takes cells and drain items, keeps the frame counters, the two line
// buffers and the 3x3 window, and hands each completed window to the queue.
// ----------------------------------------------------------------------------
module cat_front #(
	parameter int MAX_SIZE   = 256,
	parameter int VALUE_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	cat_cfg_if.sink                                 cfg,
	cat_in_if.sink                                  cell_in,
	output logic                                    win_valid,
	input  logic                                    win_ready,
	output logic [cat_pkg::WIN_CELLS-1:0][VALUE_BITS-1:0] win_cells,
	output cat_pkg::cat_flags_t                     win_flags,
	output logic [cat_pkg::THRESH_W-1:0]            threshold
);
	import cat_pkg::*;

	localparam int SIDE_W   = $clog2(MAX_SIZE + 1);
	localparam int COL_W    = $clog2(MAX_SIZE);
	localparam int ROW_W    = $clog2(MAX_SIZE + 2);
	localparam int GW       = (SIDE_W > CFG_DATA_W) ? SIDE_W : CFG_DATA_W;
	localparam int SIDE_RST = (MAX_SIZE < GRID_RST) ? MAX_SIZE : GRID_RST;

	// configuration
	logic [SIDE_W-1:0]    side_q;
	logic [THRESH_W-1:0]  thresh_q;
	logic [GW-1:0]        grid_ext;
	logic [SIDE_W-1:0]    side_new;
	logic                 cfg_acc, cfg_grid;

	// frame counters
	logic [COL_W-1:0]     col_q, ec_q, er_q;
	logic [ROW_W-1:0]     row_q;
	logic [SIDE_W-1:0]    side_m1;

	// classification
	logic                 in_acc, cells_done, emitting, ignore, proc, is_cell;
	logic                 col_wrap, ec_wrap;
	logic [VALUE_BITS-1:0] t0;
	cat_flags_t           flags;

	// line buffers
	logic [VALUE_BITS-1:0] mid_mem [MAX_SIZE];
	logic [VALUE_BITS-1:0] up_mem  [MAX_SIZE];
	logic [VALUE_BITS-1:0] mid_rd_q, up_rd_q;

	// stage 1 and window
	logic                  s1_valid_q, emit_s1, s1_move, s1_free;
	logic [VALUE_BITS-1:0] t0_s1;
	logic [COL_W-1:0]      col_s1;
	cat_flags_t            flags_s1;
	logic [WIN_CELLS-1:0][VALUE_BITS-1:0] window_q, win_next;

	assign cfg.ready = 1'b1;
	assign cfg_acc   = cfg.valid && cfg.ready;
	assign cfg_grid  = cfg_acc && (cfg.index == CFG_GRID_SIZE);
	assign threshold = thresh_q;

	// clamp the written side to the supported range
	always_comb begin
		grid_ext = GW'(cfg.data);
		if (grid_ext < GW'(MIN_SIDE)) begin
			side_new = SIDE_W'(MIN_SIDE);
		end else if (grid_ext > GW'(MAX_SIZE)) begin
			side_new = SIDE_W'(MAX_SIZE);
		end else begin
			side_new = SIDE_W'(grid_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q   <= SIDE_W'(SIDE_RST);
			thresh_q <= THRESH_W'(THRESH_RST);
		end else if (cfg_acc) begin
			unique case (cfg.index)
				CFG_GRID_SIZE: side_q   <= side_new;
				CFG_THRESHOLD: thresh_q <= THRESH_W'(cfg.data);
			endcase
		end
	end

	// item classification
	assign in_acc     = cell_in.valid && cell_in.ready;
	assign side_m1    = side_q - 1'b1;
	assign cells_done = (row_q >= ROW_W'(side_q));
	assign emitting   = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));
	assign ignore     = cell_in.drain && !cells_done;
	assign proc       = in_acc && !ignore;
	assign is_cell    = !cell_in.drain && !cells_done;
	assign t0         = is_cell ? VALUE_BITS'(cell_in.cell_value) : '0;
	assign col_wrap   = (SIDE_W'(col_q) == side_m1);
	assign ec_wrap    = (SIDE_W'(ec_q) == side_m1);

	// edge flags of the cell whose result this item releases
	always_comb begin
		flags.top_ok   = (er_q != '0);
		flags.bot_ok   = (SIDE_W'(er_q) != side_m1);
		flags.left_ok  = (ec_q != '0);
		flags.right_ok = !ec_wrap;
		flags.last     = !flags.bot_ok && ec_wrap;
	end

	// frame counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
		end else if (cfg_grid || (proc && emitting && flags.last)) begin
			col_q <= '0;
			row_q <= '0;
			ec_q  <= '0;
			er_q  <= '0;
		end else if (proc) begin
			col_q <= col_wrap ? '0 : col_q + 1'b1;
			if (col_wrap) begin
				row_q <= row_q + 1'b1;
			end
			if (emitting) begin
				ec_q <= ec_wrap ? '0 : ec_q + 1'b1;
				if (ec_wrap) begin
					er_q <= er_q + 1'b1;
				end
			end
		end
	end

	// line buffers: middle read-before-write on accept, upper written on move
	always_ff @(posedge clk) begin
		if (proc) begin
			mid_rd_q       <= mid_mem[col_q];
			up_rd_q        <= up_mem[col_q];
			mid_mem[col_q] <= t0;
		end
		if (s1_move) begin
			up_mem[col_s1] <= mid_rd_q;
		end
	end

	// stage 1 handshake
	assign s1_move       = s1_valid_q && (!emit_s1 || win_ready);
	assign s1_free       = !s1_valid_q || s1_move;
	assign cell_in.ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (proc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_move) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			t0_s1    <= t0;
			col_s1   <= col_q;
			emit_s1  <= emitting;
			flags_s1 <= flags;
		end
	end

	// window shift
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_next[r*3 + 0] = window_q[r*3 + 1];
			win_next[r*3 + 1] = window_q[r*3 + 2];
		end
		win_next[2] = up_rd_q;
		win_next[5] = mid_rd_q;
		win_next[8] = t0_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (cfg_grid || (s1_move && emit_s1 && flags_s1.last)) begin
			window_q <= '0;
		end else if (s1_move) begin
			window_q <= win_next;
		end
	end

	assign win_valid = s1_valid_q && emit_s1;
	assign win_cells = win_next;
	assign win_flags = flags_s1;

	// checks
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_free |-> (s1_valid_q && emit_s1 && !win_ready))
		else $error("front stalled without a full queue");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		SIDE_W'(col_q) < side_q)
		else $error("input column beyond grid side");
	a_emit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(SIDE_W'(ec_q) < side_q) && (SIDE_W'(er_q) < side_q))
		else $error("result position beyond grid");
	a_frame_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && emit_s1 && flags_s1.last) |=> (window_q == '0))
		else $error("window not cleared at frame end");

endmodule

/* hw/rtl/cat_back.sv */
// ----------------------------------------------------------------------------
// cat_back: rule side of the cyclic automaton step
// Counts matching neighbors inside the grid, applies the threshold rule
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module cat_back #(
	parameter int VALUE_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    win_valid,
	output logic                                    win_ready,
	input  logic [cat_pkg::WIN_CELLS-1:0][VALUE_BITS-1:0] win_cells,
	input  cat_pkg::cat_flags_t                     win_flags,
	input  logic [cat_pkg::THRESH_W-1:0]            threshold,
	cat_out_if.source                               cell_out
);
	import cat_pkg::*;

	logic [WIN_CELLS-1:0]  nb_mask;
	logic [VALUE_BITS-1:0] center, target, nv;
	logic [COUNT_W-1:0]    count;
	logic                  adv, load;
	logic                  out_valid_q;
	logic [CELL_W-1:0]     new_value_q;
	logic                  advanced_q, last_cell_q;

	// neighbors that lie inside the grid
	always_comb begin
		nb_mask[0] = win_flags.top_ok && win_flags.left_ok;
		nb_mask[1] = win_flags.top_ok;
		nb_mask[2] = win_flags.top_ok && win_flags.right_ok;
		nb_mask[3] = win_flags.left_ok;
		nb_mask[4] = 1'b0;
		nb_mask[5] = win_flags.right_ok;
		nb_mask[6] = win_flags.bot_ok && win_flags.left_ok;
		nb_mask[7] = win_flags.bot_ok;
		nb_mask[8] = win_flags.bot_ok && win_flags.right_ok;
	end

	// threshold rule; the top value never advances
	always_comb begin
		center = win_cells[WIN_CENTER];
		target = center + 1'b1;
		count  = '0;
		for (int i = 0; i < WIN_CELLS; i++) begin
			count = count + COUNT_W'(nb_mask[i] && (win_cells[i] == target));
		end
		adv = (center != '1) && (count >= threshold);
		nv  = adv ? target : center;
	end

	// output register
	assign load      = win_valid && (!out_valid_q || cell_out.ready);
	assign win_ready = !out_valid_q || cell_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (cell_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			new_value_q <= CELL_W'(nv);
			advanced_q  <= adv;
			last_cell_q <= win_flags.last;
		end
	end

	assign cell_out.valid     = out_valid_q;
	assign cell_out.new_value = new_value_q;
	assign cell_out.advanced  = advanced_q;
	assign cell_out.last_cell = last_cell_q;

endmodule
